// File: rtl/rgb2hsv_pkg.sv
`timescale 1ns / 1ps

package rgb2hsv_pkg;

  // channel and hue fixed-point format
  localparam int CHANNEL_BITS  = 8;
  localparam int HUE_FRAC_BITS = 6;

  // degrees scaled by the hue fraction
  localparam int SECTOR    = 60 << HUE_FRAC_BITS;
  localparam int SECTOR2   = 2 * SECTOR;
  localparam int FULL_TURN = 360 << HUE_FRAC_BITS;
  localparam int CHAN_FULL = (1 << CHANNEL_BITS) - 1;

  // port widths
  localparam int HUE_W = $clog2(FULL_TURN);
  localparam int SAT_W = CHANNEL_BITS;

  // divider geometry: divisors are twice a channel value
  localparam int DH_W      = CHANNEL_BITS + 1;
  localparam int QH_W      = $clog2(SECTOR2 + 1);
  localparam int AH_W      = QH_W + DH_W;
  localparam int QS_W      = SAT_W;
  localparam int AS_W      = QS_W + DH_W;
  localparam int DIV_STEPS = (QH_W > QS_W) ? QH_W : QS_W;

  // pipeline depth: input, min/max, setup, divider steps, output
  localparam int NST = DIV_STEPS + 4;

  // hue offsets per sector, modulo 2^HUE_W
  localparam logic [HUE_W-1:0] BASE_RED     = HUE_W'((1 << HUE_W) - SECTOR);
  localparam logic [HUE_W-1:0] BASE_RED_NEG = HUE_W'(5 * SECTOR);
  localparam logic [HUE_W-1:0] BASE_GREEN   = HUE_W'(SECTOR);
  localparam logic [HUE_W-1:0] BASE_BLUE    = HUE_W'(3 * SECTOR);

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sec_t;

  // one divider stage: hue and saturation quotients side by side
  typedef struct packed {
    logic [DH_W-1:0]         h_rem;
    logic [DH_W-1:0]         h_den;
    logic [QH_W-1:0]         h_lo;
    logic [QH_W-1:0]         h_q;
    logic [DH_W-1:0]         s_rem;
    logic [DH_W-1:0]         s_den;
    logic [QS_W-1:0]         s_lo;
    logic [QS_W-1:0]         s_q;
    logic [HUE_W-1:0]        base;
    logic                    gray;
    logic [CHANNEL_BITS-1:0] value;
  } dstg_t;

  // one restoring division step: {quotient bit, new remainder}
  function automatic logic [DH_W:0] div_bit(input logic [DH_W-1:0] rem,
                                            input logic [DH_W-1:0] den,
                                            input logic            din);
    logic [DH_W:0] t;
    logic [DH_W:0] diff;
    t    = {rem, din};
    diff = t - {1'b0, den};
    if (t >= {1'b0, den}) begin
      div_bit = {1'b1, diff[DH_W-1:0]};
    end else begin
      div_bit = {1'b0, t[DH_W-1:0]};
    end
  endfunction

endpackage

// File: rtl/rgb_to_hsv.sv
// channel   valid      stall       payload
// in_       in_valid   in_stall    in_red, in_green, in_blue
// out_      out_valid  out_stall   out_hue, out_saturation, out_value
//
// one pixel enters per clock while in_stall is low; the pipeline depth is
// set by the bit-per-stage restoring divider for the hue quotient.
// rst_n is synchronous and clears the stage valid bits only.
// a stage loads whenever it is empty or the stage after it moves, so bubbles
// close up under out_stall and in_stall rises only when every stage is full.
`timescale 1ns / 1ps

module rgb_to_hsv
  import rgb2hsv_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [CHANNEL_BITS-1:0] in_red,
  input  logic [CHANNEL_BITS-1:0] in_green,
  input  logic [CHANNEL_BITS-1:0] in_blue,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [HUE_W-1:0]        out_hue,
  output logic [SAT_W-1:0]        out_saturation,
  output logic [CHANNEL_BITS-1:0] out_value
);

  logic [NST-1:0] vld_r;
  logic [NST-1:0] rdy;

  logic [CHANNEL_BITS-1:0] red_r, green_r, blue_r;
  logic [CHANNEL_BITS-1:0] r1_r, g1_r, b1_r, mx1_r, mn1_r;
  logic [CHANNEL_BITS-1:0] mx_nxt, mn_nxt;
  sec_t                    sec1_r, sec_nxt;

  dstg_t dv_r   [0:DIV_STEPS];
  dstg_t dv_nxt [0:DIV_STEPS];

  logic [HUE_W-1:0]        hue_r, hue_nxt;
  logic [SAT_W-1:0]        sat_r, sat_nxt;
  logic [CHANNEL_BITS-1:0] val_r;

  // per-stage ready: load when empty or when the next stage moves
  always_comb begin
    rdy[NST-1] = !vld_r[NST-1] || !out_stall;
    for (int i = NST - 2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  assign in_stall = !rdy[0];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_valid;
      for (int i = 1; i < NST; i++) begin
        if (rdy[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // stage 1: largest and smallest channel, first channel at max wins
  always_comb begin
    mx_nxt = red_r;
    mn_nxt = red_r;
    if (green_r > mx_nxt) mx_nxt = green_r;
    if (blue_r > mx_nxt)  mx_nxt = blue_r;
    if (green_r < mn_nxt) mn_nxt = green_r;
    if (blue_r < mn_nxt)  mn_nxt = blue_r;
    if (mx_nxt == red_r) begin
      sec_nxt = SEC_RED;
    end else if (mx_nxt == green_r) begin
      sec_nxt = SEC_GREEN;
    end else begin
      sec_nxt = SEC_BLUE;
    end
  end

  // stage 2: dividends and divisors for hue and saturation
  always_comb begin
    logic [CHANNEL_BITS-1:0]   d;
    logic signed [DH_W:0]      xd;
    logic [AH_W-1:0]           ah;
    logic [AS_W-1:0]           as;
    logic                      neg;
    d   = mx1_r - mn1_r;
    neg = 1'b0;
    dv_nxt[0] = '0;
    unique case (sec1_r)
      SEC_RED: begin
        xd  = $signed({2'b00, g1_r}) - $signed({2'b00, b1_r}) + $signed({2'b00, d});
        neg = g1_r < b1_r;
        dv_nxt[0].base = neg ? BASE_RED_NEG : BASE_RED;
      end
      SEC_GREEN: begin
        xd = $signed({2'b00, b1_r}) - $signed({2'b00, r1_r}) + $signed({2'b00, d});
        dv_nxt[0].base = BASE_GREEN;
      end
      SEC_BLUE: begin
        xd = $signed({2'b00, r1_r}) - $signed({2'b00, g1_r}) + $signed({2'b00, d});
        dv_nxt[0].base = BASE_BLUE;
      end
      default: begin
        xd = '0;
        dv_nxt[0].base = '0;
      end
    endcase
    // hue: 2*S*(x + delta) + delta over 2*delta
    ah = AH_W'(SECTOR2) * AH_W'(xd[DH_W-1:0]) + AH_W'(d);
    // saturation: 2*delta*full + max over 2*max
    as = AS_W'({d, 1'b0}) * AS_W'(CHAN_FULL) + AS_W'(mx1_r);
    dv_nxt[0].h_den = {d, 1'b0};
    dv_nxt[0].h_rem = ah[AH_W-1:QH_W];
    dv_nxt[0].h_lo  = ah[QH_W-1:0];
    dv_nxt[0].h_q   = '0;
    dv_nxt[0].s_den = {mx1_r, 1'b0};
    dv_nxt[0].s_rem = as[AS_W-1:QS_W];
    dv_nxt[0].s_lo  = as[QS_W-1:0];
    dv_nxt[0].s_q   = '0;
    dv_nxt[0].gray  = (d == '0);
    dv_nxt[0].value = mx1_r;
  end

  // divider stages: one hue quotient bit per stage, and one saturation quotient bit per stage in the last QS_W stages
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    logic [DH_W:0] hb, sb;
    always_comb begin
      dv_nxt[j+1] = dv_r[j];
      hb = div_bit(dv_r[j].h_rem, dv_r[j].h_den, dv_r[j].h_lo[QH_W-1]);
      sb = div_bit(dv_r[j].s_rem, dv_r[j].s_den, dv_r[j].s_lo[QS_W-1]);
      if (j >= DIV_STEPS - QH_W) begin
        dv_nxt[j+1].h_rem = hb[DH_W-1:0];
        dv_nxt[j+1].h_q   = QH_W'({dv_r[j].h_q, hb[DH_W]});
        dv_nxt[j+1].h_lo  = dv_r[j].h_lo << 1;
      end
      if (j >= DIV_STEPS - QS_W) begin
        dv_nxt[j+1].s_rem = sb[DH_W-1:0];
        dv_nxt[j+1].s_q   = QS_W'({dv_r[j].s_q, sb[DH_W]});
        dv_nxt[j+1].s_lo  = dv_r[j].s_lo << 1;
      end
    end
  end

  // output stage: sector offset, full-turn wrap, gray pixel
  always_comb begin
    logic [HUE_W-1:0] sum;
    sum = dv_r[DIV_STEPS].base + HUE_W'(dv_r[DIV_STEPS].h_q);
    if (dv_r[DIV_STEPS].gray || sum >= HUE_W'(FULL_TURN)) begin
      hue_nxt = '0;
    end else begin
      hue_nxt = sum;
    end
    sat_nxt = dv_r[DIV_STEPS].gray ? '0 : dv_r[DIV_STEPS].s_q;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      red_r   <= in_red;
      green_r <= in_green;
      blue_r  <= in_blue;
    end
    if (rdy[1]) begin
      r1_r   <= red_r;
      g1_r   <= green_r;
      b1_r   <= blue_r;
      mx1_r  <= mx_nxt;
      mn1_r  <= mn_nxt;
      sec1_r <= sec_nxt;
    end
    for (int m = 0; m <= DIV_STEPS; m++) begin
      if (rdy[m+2]) dv_r[m] <= dv_nxt[m];
    end
    if (rdy[NST-1]) begin
      hue_r <= hue_nxt;
      sat_r <= sat_nxt;
      val_r <= dv_r[DIV_STEPS].value;
    end
  end

  assign out_valid      = vld_r[NST-1];
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_value      = val_r;

`ifndef NO_ASSERTIONS
  // hue always lies below a full turn
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hue < HUE_W'(FULL_TURN)))
    else $error("hue at or above full turn");

  // a black pixel has no hue and no saturation
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_value == '0) |-> (out_hue == '0 && out_saturation == '0))
    else $error("black pixel with hue or saturation");

  // input is held off only when every stage holds a request
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&vld_r))
    else $error("input stalled with a bubble in the pipeline");
`endif

endmodule
